/* hw/rtl/bdwd_pkg.sv */
// bdwd_pkg: block size, dialect table and the fp32 decode of one 4-bit code
// used by block_dialect_weight_dequantizer; no dependencies
package bdwd_pkg;

  localparam int PAIRS_PER_BLOCK = 16;
  localparam int POS_W = $clog2(PAIRS_PER_BLOCK + 2);
  localparam int EXP_BIAS_LESS_SHIFT = 111;

  localparam logic [POS_W-1:0] POS_HDR_HIGH = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR_LOW  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_FIRST    = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LAST     = POS_W'(PAIRS_PER_BLOCK + 1);

  typedef logic [POS_W-1:0] pos_t;

  function automatic logic [3:0] dialect_mag(input logic [3:0] dialect,
                                             input logic [2:0] index);
    logic [3:0] hi6;
    logic [3:0] hi7;
    begin
      unique case (dialect)
        4'd0:    begin hi6 = 4'd11; hi7 = 4'd15; end
        4'd1:    begin hi6 = 4'd9;  hi7 = 4'd15; end
        4'd2:    begin hi6 = 4'd11; hi7 = 4'd14; end
        4'd3:    begin hi6 = 4'd9;  hi7 = 4'd14; end
        4'd4:    begin hi6 = 4'd10; hi7 = 4'd13; end
        4'd5:    begin hi6 = 4'd8;  hi7 = 4'd13; end
        4'd6:    begin hi6 = 4'd10; hi7 = 4'd12; end
        4'd7:    begin hi6 = 4'd8;  hi7 = 4'd12; end
        4'd8:    begin hi6 = 4'd9;  hi7 = 4'd11; end
        4'd9:    begin hi6 = 4'd7;  hi7 = 4'd11; end
        4'd10:   begin hi6 = 4'd9;  hi7 = 4'd10; end
        4'd11:   begin hi6 = 4'd7;  hi7 = 4'd10; end
        4'd12:   begin hi6 = 4'd8;  hi7 = 4'd9;  end
        4'd13:   begin hi6 = 4'd7;  hi7 = 4'd9;  end
        4'd14:   begin hi6 = 4'd7;  hi7 = 4'd8;  end
        default: begin hi6 = 4'd6;  hi7 = 4'd8;  end
      endcase
      unique case (index)
        3'd0:    dialect_mag = 4'd0;
        3'd1:    dialect_mag = 4'd1;
        3'd2:    dialect_mag = 4'd2;
        3'd3:    dialect_mag = 4'd3;
        3'd4:    dialect_mag = 4'd4;
        3'd5:    dialect_mag = (dialect == 4'd15) ? 4'd5 : 4'd6;
        3'd6:    dialect_mag = hi6;
        default: dialect_mag = hi7;
      endcase
    end
  endfunction

  function automatic logic [31:0] decode_code(input logic [3:0] dialect,
                                              input logic [4:0] exponent,
                                              input logic [3:0] code);
    logic [3:0]  mag;
    logic [1:0]  top;
    logic [7:0]  biased;
    logic [26:0] shifted;
    begin
      mag = dialect_mag(dialect, code[2:0]);
      priority if (mag[3]) top = 2'd3;
      else if (mag[2])     top = 2'd2;
      else if (mag[1])     top = 2'd1;
      else                 top = 2'd0;
      biased  = 8'(EXP_BIAS_LESS_SHIFT) + {6'd0, top} + {3'd0, exponent};
      shifted = {mag, 23'd0} >> top;
      if (mag == 4'd0) begin
        decode_code = {code[3], 31'd0};
      end else begin
        decode_code = {code[3], biased, shifted[22:0]};
      end
    end
  endfunction

endpackage

/* hw/rtl/block_dialect_weight_dequantizer.sv */
// block_dialect_weight_dequantizer: top level, byte stream to fp32 weight pairs
// depends on bdwd_pkg for the dialect table and the code decode
//
// usage
// - input channel: byte_in with in_valid/in_ready, one byte per transaction;
//   each block is a two-byte big-endian header then 16 code bytes
// - output channel: value_first, value_second, pair_index, block_done with
//   out_valid/out_ready, one transaction per code byte, none for header bytes
// - a code byte is decoded in the cycle it is taken and the result appears
//   in the output register in the next cycle
// - throughput, no stall: one byte per cycle; single output register refilled
//   in the same cycle it is emptied, so in_ready = !out_valid || out_ready
// - receiver stall: while out_valid is high and out_ready low, in_ready is
//   low and the held result does not change
// - reset: the output register empties and the next byte is taken as the
//   high byte of a block header; dialect and exponent clear to zero
// - header bits 6..0 of the low byte are ignored; after the last code byte
//   the next byte starts a new block
module block_dialect_weight_dequantizer
  import bdwd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  byte_in,
  input  logic        in_valid,
  output logic        in_ready,
  output logic [31:0] value_first,
  output logic [31:0] value_second,
  output logic [3:0]  pair_index,
  output logic        block_done,
  output logic        out_valid,
  input  logic        out_ready
);

  pos_t       byte_position;
  pos_t       byte_position_next;
  logic [7:0] header_high;
  logic [3:0] dialect_reg;
  logic [4:0] exponent_reg;
  logic       in_take;
  logic       is_code;
  logic       is_last;
  logic [3:0] pair_low;

  assign in_ready  = !out_valid || out_ready;
  assign in_take   = in_valid && in_ready;
  assign is_code   = (byte_position != POS_HDR_HIGH) && (byte_position != POS_HDR_LOW);
  assign is_last   = (byte_position == POS_LAST);
  assign pair_low  = 4'(byte_position - POS_FIRST);

  always_comb begin
    if (is_last) begin
      byte_position_next = POS_HDR_HIGH;
    end else begin
      byte_position_next = byte_position + POS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_HDR_HIGH;
      header_high   <= 8'd0;
      dialect_reg   <= 4'd0;
      exponent_reg  <= 5'd0;
      out_valid     <= 1'b0;
    end else begin
      if (in_take && is_code) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_take) begin
        byte_position <= byte_position_next;
        if (byte_position == POS_HDR_HIGH) begin
          header_high <= byte_in;
        end
        if (byte_position == POS_HDR_LOW) begin
          dialect_reg  <= header_high[7:4];
          exponent_reg <= {header_high[3:0], byte_in[7]};
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_take && is_code) begin
      value_first  <= decode_code(dialect_reg, exponent_reg, byte_in[7:4]);
      value_second <= decode_code(dialect_reg, exponent_reg, byte_in[3:0]);
      pair_index   <= pair_low;
      block_done   <= is_last;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    byte_position <= POS_LAST)
    else $error("byte position beyond end of block");

  a_header_no_result: assert property (@(posedge clk) disable iff (rst)
    in_take && !is_code && out_ready |=> !out_valid)
    else $error("header byte produced a result");

  a_done_on_last_pair: assert property (@(posedge clk) disable iff (rst)
    in_take && is_last |=> out_valid && block_done)
    else $error("last code byte did not mark block_done");

  a_header_restart: assert property (@(posedge clk) disable iff (rst)
    in_take && is_last |=> byte_position == POS_HDR_HIGH)
    else $error("block did not wrap to header");

endmodule
